@@ rtl/prarq_pkg.sv @@
// Package with the item types, codes and sizes of the partial reliability ARQ sender.
`timescale 1ns / 1ps

package prarq_pkg;

	// Depth of the outcome window and the widths that follow from it.
	localparam int WINDOW = 100;
	localparam int POS_W = $clog2(WINDOW);
	localparam int LOSS_W = 7;
	localparam int LIMIT_W = 7;
	localparam int SENDS_W = 8;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SENDS = 1'd1;
	localparam logic [LIMIT_W-1:0] LOSS_LIMIT_RESET = 7'd0;
	localparam logic [SENDS_W-1:0] MAX_SENDS_RESET = 8'd100;

	// Event kinds.
	localparam logic [1:0] KIND_NEW = 2'd0;
	localparam logic [1:0] KIND_TIMEOUT = 2'd1;
	localparam logic [1:0] KIND_REPLY = 2'd2;

	// Result actions.
	localparam logic [2:0] ACT_SEND = 3'd0;
	localparam logic [2:0] ACT_RESEND = 3'd1;
	localparam logic [2:0] ACT_DONE = 3'd2;
	localparam logic [2:0] ACT_SKIP = 3'd3;
	localparam logic [2:0] ACT_ABORT = 3'd4;
	localparam logic [2:0] ACT_IDLE = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic       reply_ack_flag;
		logic       reply_ack_bit;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        action;
		logic              seq_bit;
		logic [LOSS_W-1:0] loss_count;
	} out_item_t;

endpackage

@@ rtl/partial_reliability_arq_sender.sv @@
// Top level of the partial reliability stop-and-wait ARQ sender.
`timescale 1ns / 1ps

// Sender side of an alternating-bit stop-and-wait link that tolerates a
// bounded number of losses. Each input transfer on in_data is one event: a
// new message, a reply timeout, or a received reply. Every event yields
// exactly one output transfer on out_data with the action to take, the
// sequence bit of the segment concerned and the loss count in the window.
// Both channels use valid and stall; a transfer happens on a rising edge
// with valid high and stall low.
// An event is held in an input register, then decided and written into the
// output register. One event can be taken every cycle; the input stalls
// only while the input register holds an event that cannot move because
// the output register is full and stalled.
// The outcome window is a 1-bit memory with a registered read that always
// prefetches the slot at the next write position. Until the write position
// has wrapped once, slots count as clean, so no clearing pass is needed.
// Reset clears the control state, loss_limit to 0 and max_sends to 100.
// Configuration writes through cfg_en, cfg_index and cfg_data are taken
// whenever cfg_en is high and must be made while the block is idle.
module partial_reliability_arq_sender (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_en,
	input  logic [prarq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [prarq_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  prarq_pkg::in_item_t                    in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output prarq_pkg::out_item_t                   out_data
);

	localparam logic [prarq_pkg::POS_W-1:0] POS_LAST = prarq_pkg::POS_W'(prarq_pkg::WINDOW - 1);

	// Configuration registers.
	logic [prarq_pkg::LIMIT_W-1:0] loss_limit_q;
	logic [prarq_pkg::SENDS_W-1:0] max_sends_q;

	// Input stage.
	logic                 valid_s1;
	prarq_pkg::in_item_t  item_s1;

	// Output register.
	logic                 out_valid_q;
	prarq_pkg::out_item_t out_q;

	// Protocol state.
	logic [prarq_pkg::POS_W-1:0]   pos_q;
	logic                          wrapped_q;
	logic [prarq_pkg::LOSS_W-1:0]  losses_q;
	logic                          bit_q;
	logic [prarq_pkg::SENDS_W-1:0] attempts_q;
	logic                          pending_q;

	// Outcome window and its prefetched read.
	logic win_mem [prarq_pkg::WINDOW];
	logic win_rd_q;

	// Decision logic.
	logic                          advance;
	logic                          rec;
	logic                          lost;
	logic                          resend;
	logic [2:0]                    act;
	logic                          pending_n;
	logic [prarq_pkg::SENDS_W-1:0] attempts_n;
	logic                          bit_n;
	logic                          old_loss;
	logic [prarq_pkg::LOSS_W-1:0]  losses_n;
	logic [prarq_pkg::POS_W-1:0]   pos_inc;
	logic [prarq_pkg::POS_W-1:0]   pos_next;
	logic                          wr_en;

	// The input register moves on when the output register is free or
	// is being emptied in this cycle.
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		act = prarq_pkg::ACT_IDLE;
		pending_n = pending_q;
		attempts_n = attempts_q;
		bit_n = bit_q;
		rec = 1'b0;
		lost = 1'b0;
		resend = 1'b0;
		unique case (item_s1.kind)
			prarq_pkg::KIND_NEW: begin
				if (!pending_q) begin
					pending_n = 1'b1;
					attempts_n = '0;
					act = prarq_pkg::ACT_SEND;
				end
			end
			prarq_pkg::KIND_TIMEOUT: begin
				if (pending_q) begin
					// At the loss limit a timeout must be retransmitted;
					// otherwise the message is given up and logged as lost.
					if (losses_q == loss_limit_q) begin
						resend = 1'b1;
					end else begin
						rec = 1'b1;
						lost = 1'b1;
						pending_n = 1'b0;
						attempts_n = '0;
						act = prarq_pkg::ACT_SKIP;
					end
				end
			end
			prarq_pkg::KIND_REPLY: begin
				if (pending_q) begin
					if (item_s1.reply_ack_flag && (item_s1.reply_ack_bit == bit_q)) begin
						rec = 1'b1;
						pending_n = 1'b0;
						attempts_n = '0;
						bit_n = ~bit_q;
						act = prarq_pkg::ACT_DONE;
					end else begin
						resend = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		// A retransmission past the budget aborts the message instead.
		if (resend) begin
			if (attempts_q >= max_sends_q) begin
				pending_n = 1'b0;
				attempts_n = '0;
				act = prarq_pkg::ACT_ABORT;
			end else begin
				attempts_n = attempts_q + prarq_pkg::SENDS_W'(1);
				act = prarq_pkg::ACT_RESEND;
			end
		end
	end

	// The slot being replaced only counts once it has been written.
	assign old_loss = wrapped_q && win_rd_q;
	assign losses_n = rec
		? (losses_q - prarq_pkg::LOSS_W'(old_loss) + prarq_pkg::LOSS_W'(lost))
		: losses_q;
	assign wr_en = advance && rec;
	assign pos_inc = (pos_q == POS_LAST) ? '0 : (pos_q + prarq_pkg::POS_W'(1));
	assign pos_next = wr_en ? pos_inc : pos_q;

	// Window memory: write the outcome at the current slot and prefetch the
	// slot that will be current in the next cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_mem[pos_q] <= lost;
		end
		win_rd_q <= win_mem[pos_next];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_limit_q <= prarq_pkg::LOSS_LIMIT_RESET;
			max_sends_q <= prarq_pkg::MAX_SENDS_RESET;
		end else if (cfg_en) begin
			unique case (cfg_index)
				prarq_pkg::REG_LOSS_LIMIT: loss_limit_q <= cfg_data[prarq_pkg::LIMIT_W-1:0];
				prarq_pkg::REG_MAX_SENDS: max_sends_q <= cfg_data[prarq_pkg::SENDS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q <= '0;
			wrapped_q <= 1'b0;
			losses_q <= '0;
			bit_q <= 1'b0;
			attempts_q <= '0;
			pending_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				pending_q <= pending_n;
				attempts_q <= attempts_n;
				bit_q <= bit_n;
				losses_q <= losses_n;
				pos_q <= pos_next;
				if (rec && (pos_q == POS_LAST)) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_q.action <= act;
			out_q.seq_bit <= bit_q;
			out_q.loss_count <= losses_n;
		end
	end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the partial reliability stop-and-wait ARQ sender.
`timescale 1ns / 1ps

module tb_top;

	// Length of the long receiver hold-off that lets the block fill up.
	localparam int HOLD_CYCLES = 60;
	// Cycles to let pass after the last result before touching the registers.
	localparam int SETTLE_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_en = 1'b0;
	logic [prarq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [prarq_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	prarq_pkg::in_item_t  in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	prarq_pkg::out_item_t out_data;

	// Idle and stall rates in percent, changed from phase to phase.
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	// A test raises hold_go to start one long hold-off; the receiver process
	// counts it down in hold_left.
	bit          hold_go = 1'b0;
	int          hold_left = 0;

	int          mismatch_cnt = 0;
	int          events_sent = 0;

	// Actions predicted for accepted events, oldest first.
	prarq_pkg::out_item_t expected_actions[$];

	// Shadow copy of the sender's state and registers. It advances exactly
	// once per accepted event, in acceptance order.
	bit               lost_slot[prarq_pkg::WINDOW];
	int               win_ptr = 0;
	int               lost_cnt = 0;
	logic             tx_bit = 1'b0;
	int               retries = 0;
	bit               outstanding = 1'b0;
	logic [prarq_pkg::LIMIT_W-1:0] lim_loss = prarq_pkg::LOSS_LIMIT_RESET;
	logic [prarq_pkg::SENDS_W-1:0] lim_sends = prarq_pkg::MAX_SENDS_RESET;

	always #2 clk = ~clk;

	partial_reliability_arq_sender u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Store one outcome in the window. The slot being reused holds the oldest
	// outcome, so the running loss count drops by whatever it held.
	function automatic void log_outcome(bit lost);
		if (lost_slot[win_ptr])
			lost_cnt--;
		lost_slot[win_ptr] = lost;
		if (lost)
			lost_cnt++;
		win_ptr = (win_ptr + 1) % prarq_pkg::WINDOW;
	endfunction

	// A retransmission is due. Once the budget is used up the message is
	// dropped instead; the window and the sequence bit are left alone.
	function automatic logic [2:0] resend_or_abort();
		if (retries >= lim_sends) begin
			outstanding = 1'b0;
			retries = 0;
			return prarq_pkg::ACT_ABORT;
		end
		retries++;
		return prarq_pkg::ACT_RESEND;
	endfunction

	// Work out the action for one event and advance the shadow state.
	function automatic prarq_pkg::out_item_t arq_decide(prarq_pkg::in_item_t evt);
		prarq_pkg::out_item_t r;
		r.action = prarq_pkg::ACT_IDLE;
		// The reported bit is the one of the message concerned, taken before
		// a delivery flips it.
		r.seq_bit = tx_bit;
		case (evt.kind)
			prarq_pkg::KIND_NEW: begin
				// A new message while one is outstanding is ignored.
				if (!outstanding) begin
					outstanding = 1'b1;
					retries = 0;
					r.action = prarq_pkg::ACT_SEND;
				end
			end
			prarq_pkg::KIND_TIMEOUT: begin
				if (outstanding) begin
					// Equality only: with the count above a lowered limit,
					// timeouts keep skipping.
					if (lost_cnt == lim_loss) begin
						r.action = resend_or_abort();
					end else begin
						log_outcome(1'b1);
						outstanding = 1'b0;
						retries = 0;
						r.action = prarq_pkg::ACT_SKIP;
					end
				end
			end
			prarq_pkg::KIND_REPLY: begin
				if (outstanding) begin
					if (evt.reply_ack_flag && evt.reply_ack_bit == tx_bit) begin
						log_outcome(1'b0);
						outstanding = 1'b0;
						retries = 0;
						tx_bit = ~tx_bit;
						r.action = prarq_pkg::ACT_DONE;
					end else begin
						r.action = resend_or_abort();
					end
				end
			end
			default: ;
		endcase
		r.loss_count = lost_cnt[prarq_pkg::LOSS_W-1:0];
		return r;
	endfunction

	function automatic prarq_pkg::in_item_t mk_event(logic [1:0] kind, logic flag, logic abit);
		prarq_pkg::in_item_t e;
		e.kind = kind;
		e.reply_ack_flag = flag;
		e.reply_ack_bit = abit;
		return e;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_cnt++;
	endtask

	// Offer one event and return at the edge where it is taken. Random idle
	// cycles go in front of it. Must be called right after a rising edge.
	task automatic xfer(prarq_pkg::in_item_t item);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		expected_actions.push_back(arq_decide(item));
		events_sent++;
	endtask

	// Stop offering and wait until every predicted action has come out, then
	// a few more cycles so the pipeline is empty.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_actions.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; only called with the block idle.
	task automatic write_reg(logic [prarq_pkg::CFG_IDX_W-1:0] idx,
			logic [prarq_pkg::CFG_DATA_W-1:0] val);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == prarq_pkg::REG_LOSS_LIMIT)
			lim_loss = val[prarq_pkg::LIMIT_W-1:0];
		else
			lim_sends = val[prarq_pkg::SENDS_W-1:0];
		cfg_en <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed exchanges: a new message, a few failures (timeouts,
	// replies without ack, replies with the wrong bit) and then usually the
	// matching ack. The rest is noise of any kind, the unused one included.
	task automatic random_items(int n);
		int first;
		int fails;
		first = events_sent;
		while (events_sent - first < n) begin
			if ($urandom_range(9) < 8) begin
				xfer(mk_event(prarq_pkg::KIND_NEW, 1'($urandom_range(1)),
					1'($urandom_range(1))));
				fails = ($urandom_range(3) == 0) ? $urandom_range(6, 1) : $urandom_range(1);
				repeat (fails) begin
					case ($urandom_range(2))
						0: xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'($urandom_range(1)),
							1'($urandom_range(1))));
						1: xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b0,
							1'($urandom_range(1))));
						default: xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, ~tx_bit));
					endcase
				end
				if ($urandom_range(3) != 0)
					xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, tx_bit));
				else
					xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'($urandom_range(1)),
						1'($urandom_range(1))));
			end else begin
				xfer(mk_event(2'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1))));
			end
		end
	endtask

	// Hand-picked events at the reset settings and then at a few chosen
	// register values: events with nothing outstanding, the unused kind, a
	// duplicate new message, every kind of bad reply, forced retransmission
	// at limit zero, skipping, abort at a budget of one and a limit lowered
	// below the current loss count.
	task automatic test_directed();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, 1'b1));
		xfer(mk_event(2'd3, 1'b1, 1'b1));
		xfer(mk_event(prarq_pkg::KIND_NEW, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_NEW, 1'b1, 1'b1));
		xfer(mk_event(2'd3, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, 1'b1));
		xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'b1, 1'b1));
		xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_NEW, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, 1'b1));
		wait_for_results();
		write_reg(prarq_pkg::REG_LOSS_LIMIT, 8'd100);
		write_reg(prarq_pkg::REG_MAX_SENDS, 8'd1);
		xfer(mk_event(prarq_pkg::KIND_NEW, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_NEW, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b0, 1'b1));
		xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, 1'b1));
		xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_NEW, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'b0, 1'b0));
		wait_for_results();
		write_reg(prarq_pkg::REG_LOSS_LIMIT, 8'd1);
		xfer(mk_event(prarq_pkg::KIND_NEW, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'b0, 1'b0));
		wait_for_results();
		write_reg(prarq_pkg::REG_LOSS_LIMIT, 8'd3);
		write_reg(prarq_pkg::REG_MAX_SENDS, 8'd255);
		xfer(mk_event(prarq_pkg::KIND_NEW, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'b0, 1'b0));
		xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, 1'b0));
	endtask

	// Drive the loss count all the way up to a full window at a limit equal to
	// the window size, so timeouts turn into retransmissions there, and wrap the
	// window position once. Then lower the limit and bring the count back
	// down with acknowledged messages that overwrite old losses.
	task automatic test_window_wrap();
		int i;
		wait_for_results();
		write_reg(prarq_pkg::REG_LOSS_LIMIT, 8'd100);
		write_reg(prarq_pkg::REG_MAX_SENDS, 8'd2);
		src_idle_pct = 28;
		sink_stall_pct = 28;
		for (i = 0; i < 105; i++) begin
			xfer(mk_event(prarq_pkg::KIND_NEW, 1'b0, 1'b0));
			xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'b0, 1'b0));
			if (outstanding)
				xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, tx_bit));
		end
		wait_for_results();
		write_reg(prarq_pkg::REG_LOSS_LIMIT, 8'd50);
		for (i = 0; i < 45; i++) begin
			xfer(mk_event(prarq_pkg::KIND_NEW, 1'b1, 1'b1));
			if (i % 4 == 0)
				xfer(mk_event(prarq_pkg::KIND_TIMEOUT, 1'b1, 1'b0));
			if (outstanding)
				xfer(mk_event(prarq_pkg::KIND_REPLY, 1'b1, tx_bit));
		end
	endtask

	// Random traffic in four idling phases, each with its own register values.
	task automatic test_random_traffic();
		int ph;
		for (ph = 0; ph < 4; ph++) begin
			wait_for_results();
			case (ph)
				0: begin
					write_reg(prarq_pkg::REG_LOSS_LIMIT, 8'd0);
					write_reg(prarq_pkg::REG_MAX_SENDS, 8'd255);
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					write_reg(prarq_pkg::REG_LOSS_LIMIT, 8'd2);
					write_reg(prarq_pkg::REG_MAX_SENDS, 8'd1);
					src_idle_pct = 71;
					sink_stall_pct = 0;
				end
				2: begin
					write_reg(prarq_pkg::REG_LOSS_LIMIT, 8'($urandom_range(100)));
					write_reg(prarq_pkg::REG_MAX_SENDS, 8'($urandom_range(8, 1)));
					src_idle_pct = 0;
					sink_stall_pct = 71;
				end
				default: begin
					write_reg(prarq_pkg::REG_LOSS_LIMIT, 8'd100);
					write_reg(prarq_pkg::REG_MAX_SENDS, 8'd3);
					src_idle_pct = 28;
					sink_stall_pct = 28;
				end
			endcase
			random_items(200);
		end
	endtask

	// The receiver holds off for a long stretch while events keep coming, so
	// both pipeline registers fill and the input stalls. Afterwards the
	// sender pauses until every result is out.
	task automatic test_backpressure();
		wait_for_results();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_go = 1'b1;
		random_items(40);
		wait_for_results();
	endtask

	// Receiver side: random stalls at the current rate, forced high while a
	// hold-off is counting down.
	always @(posedge clk) begin : sink_ctl
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left--;
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < sink_stall_pct);
	end

	// Every output transfer is matched against the oldest prediction.
	always @(posedge clk) begin : chk_results
		prarq_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_actions.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, action %0d",
					out_data.action));
			end else begin
				want = expected_actions.pop_front();
				if (out_data.action !== want.action)
					report_mismatch($sformatf("action got %0d expected %0d",
						out_data.action, want.action));
				if (out_data.seq_bit !== want.seq_bit)
					report_mismatch($sformatf("seq_bit got %0d expected %0d",
						out_data.seq_bit, want.seq_bit));
				if (out_data.loss_count !== want.loss_count)
					report_mismatch($sformatf("loss_count got %0d expected %0d",
						out_data.loss_count, want.loss_count));
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_window_wrap();
		test_random_traffic();
		test_backpressure();
		wait_for_results();
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
